// ===== rtl/pqsa_pkg.sv =====
// ---------------------------------------------------------------------------
// pqsa_pkg: shared types and constants for the seat allocator.
// Holds sizes, status and action codes, and the controller/datapath structs.
// ---------------------------------------------------------------------------
`default_nettype none
package pqsa_pkg;
  localparam int QUEUE_DEPTH   = 16;
  localparam int MAX_ROWS      = 8;
  localparam int SLOTS_PER_ROW = 8;
  localparam int PRIO_MAX      = 5;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int SW = $clog2(SLOTS_PER_ROW);
  localparam int NSLOT = MAX_ROWS * SLOTS_PER_ROW;
  localparam int AW = $clog2(NSLOT);

  typedef enum logic [1:0] {
    ACT_ENQ = 2'd0, ACT_SERVE = 2'd1, ACT_ADD_ROW = 2'd2, ACT_ADD_SLOT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_QFULL = 3'd1, ST_QEMPTY = 3'd2, ST_NOSLOT = 3'd3,
    ST_BADROW = 3'd4, ST_NOROOM = 3'd5
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word
    logic scan_step;  // one step of the slot search
    logic execute;    // commit the operation
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_serve;   // captured action needs a slot search
    logic scan_done;  // search finished (found or exhausted)
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/priority_queue_seat_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// priority_queue_seat_allocator_unit: priority request queue with seating.
// Keeps requests sorted by priority (stable) and seats the head request in
// the first free slot, rows in order and slots in insertion order.
// ---------------------------------------------------------------------------
//  channel | direction | tdata fields (low bit first)
//  in_     | slave     | action[1:0] item_id[17:2] priority_req[20:18] row_number[24:21]
//  out_    | master    | status[2:0] served_tag[18:3] served_priority[21:19]
//          |           | assigned_row[25:22] assigned_slot[41:26]
//
// A word steps through idle, scan, read, exec and out; one that needs no search
// leaves scan at once. A serve stays in scan for one search step per slot
// examined, per row passed and one more when no slot is free.
// One word is in flight at a time; in_tready drops until the result is taken.
// A stalled out_tready holds the result and the input side.
// Synchronous active-low reset empties the queue and the row table.
`default_nettype none
module priority_queue_seat_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // action, item_id, priority_req, row_number
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // status, served_tag, served_priority,
                                       // assigned_row, assigned_slot
);
  pqsa_pkg::dp_cmd_t  cmd;
  pqsa_pkg::dp_stat_t stat;
  logic [41:0]        result;

  pqsa_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .cmd, .stat
  );

  pqsa_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .in_word(in_tdata[24:0]), .result
  );

  assign out_tdata = {6'd0, result};
endmodule
`default_nettype wire

// ===== rtl/pqsa_datapath.sv =====
// ---------------------------------------------------------------------------
// pqsa_datapath: queue, row table and slot search.
// The queue is a sorted shift register; the search walks one slot a cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module pqsa_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pqsa_pkg::dp_cmd_t cmd,
  output pqsa_pkg::dp_stat_t    stat,
  input  wire logic [24:0]      in_word,
  output logic [41:0]           result
);
  logic [1:0]  act_r;
  logic [15:0] item_r;
  logic [2:0]  prio_r;
  logic [3:0]  row_r;

  logic [15:0] qtag_r  [pqsa_pkg::QUEUE_DEPTH];
  logic [2:0]  qpri_r  [pqsa_pkg::QUEUE_DEPTH];
  logic [pqsa_pkg::QW:0] qcnt_r;
  logic [pqsa_pkg::RW:0] rows_r;
  logic [pqsa_pkg::SW:0] used_r [pqsa_pkg::MAX_ROWS];
  logic [pqsa_pkg::NSLOT-1:0] taken_r;
  logic [15:0] slotnum_mem [pqsa_pkg::NSLOT];

  // Search position: row and slot counters.
  logic [pqsa_pkg::RW:0] srow_r;
  logic [pqsa_pkg::SW:0] sslot_r;
  logic                  found_r, done_r;
  logic [pqsa_pkg::AW-1:0] fidx_r;
  logic [pqsa_pkg::RW:0] frow_r;

  logic [2:0] p_clamp;
  logic [pqsa_pkg::AW-1:0] sidx;
  logic [pqsa_pkg::RW-1:0] srow_i;
  logic [pqsa_pkg::RW-1:0] arow;
  logic [pqsa_pkg::AW-1:0] aidx;
  logic [15:0] num_q;
  logic [2:0] st;

  assign p_clamp = (prio_r == 3'd0) ? 3'd1 :
                   (prio_r > 3'(pqsa_pkg::PRIO_MAX)) ? 3'(pqsa_pkg::PRIO_MAX) : prio_r;
  assign srow_i = srow_r[pqsa_pkg::RW-1:0];
  assign sidx = {srow_i, sslot_r[pqsa_pkg::SW-1:0]};
  assign arow = pqsa_pkg::RW'(row_r - 4'd1);
  assign aidx = {arow, used_r[arow][pqsa_pkg::SW-1:0]};
  assign stat.is_serve = (act_r == pqsa_pkg::ACT_SERVE) && (qcnt_r != '0);
  assign stat.scan_done = done_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_word[1:0]; item_r <= in_word[17:2];
      prio_r <= in_word[20:18]; row_r <= in_word[24:21];
    end
    if (cmd.execute && act_r == pqsa_pkg::ACT_ADD_SLOT && st == pqsa_pkg::ST_OK)
      slotnum_mem[aidx] <= item_r;
    if (found_r) num_q <= slotnum_mem[fidx_r];
  end

  // Slot search: one slot examined per cycle, rows in order.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      srow_r <= '0; sslot_r <= '0; found_r <= 1'b0; done_r <= 1'b0;
    end else if (cmd.scan_step && !done_r) begin
      if (srow_r >= rows_r) begin
        done_r <= 1'b1;
      end else if (sslot_r >= used_r[srow_i]) begin
        srow_r <= srow_r + 1'b1; sslot_r <= '0;
      end else if (!taken_r[sidx]) begin
        found_r <= 1'b1; fidx_r <= sidx; frow_r <= srow_r; done_r <= 1'b1;
      end else begin
        sslot_r <= sslot_r + 1'b1;
      end
    end
  end

  always_comb begin
    st = pqsa_pkg::ST_OK;
    case (pqsa_pkg::action_t'(act_r))
      pqsa_pkg::ACT_ENQ:
        if (qcnt_r >= (pqsa_pkg::QW+1)'(pqsa_pkg::QUEUE_DEPTH)) st = pqsa_pkg::ST_QFULL;
      pqsa_pkg::ACT_SERVE:
        if (qcnt_r == '0) st = pqsa_pkg::ST_QEMPTY;
        else if (!found_r) st = pqsa_pkg::ST_NOSLOT;
      pqsa_pkg::ACT_ADD_ROW:
        if (rows_r >= (pqsa_pkg::RW+1)'(pqsa_pkg::MAX_ROWS)) st = pqsa_pkg::ST_NOROOM;
      pqsa_pkg::ACT_ADD_SLOT:
        if (row_r == 4'd0 || row_r > 4'(rows_r)) st = pqsa_pkg::ST_BADROW;
        else if (used_r[arow] >= (pqsa_pkg::SW+1)'(pqsa_pkg::SLOTS_PER_ROW))
          st = pqsa_pkg::ST_NOROOM;
      default: st = pqsa_pkg::ST_OK;
    endcase
  end

  // Result: status, tag, priority, row, slot from the lowest bit up.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (act_r == pqsa_pkg::ACT_SERVE && st == pqsa_pkg::ST_OK)
        result <= {num_q, 4'(frow_r) + 4'd1, qpri_r[0], qtag_r[0], st};
      else
        result <= {39'd0, st};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= '0; rows_r <= '0; taken_r <= '0;
      for (int r = 0; r < pqsa_pkg::MAX_ROWS; r++) used_r[r] <= '0;
    end else if (cmd.execute && st == pqsa_pkg::ST_OK) begin
      case (pqsa_pkg::action_t'(act_r))
        pqsa_pkg::ACT_ENQ: begin
          // Shift the tail up and drop the new entry after equal priorities.
          for (int i = 0; i < pqsa_pkg::QUEUE_DEPTH; i++) begin
            if ((pqsa_pkg::QW+1)'(i) < qcnt_r && qpri_r[i] <= p_clamp) begin
            end else if (i > 0 && (pqsa_pkg::QW+1)'(i-1) < qcnt_r
                         && qpri_r[i-1] > p_clamp) begin
              qtag_r[i] <= qtag_r[i-1]; qpri_r[i] <= qpri_r[i-1];
            end else if ((pqsa_pkg::QW+1)'(i) <= qcnt_r) begin
              qtag_r[i] <= item_r; qpri_r[i] <= p_clamp;
            end
          end
          qcnt_r <= qcnt_r + 1'b1;
        end
        pqsa_pkg::ACT_SERVE: begin
          for (int i = 0; i < pqsa_pkg::QUEUE_DEPTH - 1; i++) begin
            qtag_r[i] <= qtag_r[i+1]; qpri_r[i] <= qpri_r[i+1];
          end
          taken_r[fidx_r] <= 1'b1;
          qcnt_r <= qcnt_r - 1'b1;
        end
        pqsa_pkg::ACT_ADD_ROW: begin
          used_r[rows_r[pqsa_pkg::RW-1:0]] <= '0;
          for (int s = 0; s < pqsa_pkg::SLOTS_PER_ROW; s++)
            taken_r[{rows_r[pqsa_pkg::RW-1:0], pqsa_pkg::SW'(s)}] <= 1'b0;
          rows_r <= rows_r + 1'b1;
        end
        pqsa_pkg::ACT_ADD_SLOT: begin
          taken_r[aidx] <= 1'b0;
          used_r[arow] <= used_r[arow] + 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= (pqsa_pkg::QW+1)'(pqsa_pkg::QUEUE_DEPTH)) else $error("queue overflow");
  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r <= (pqsa_pkg::RW+1)'(pqsa_pkg::MAX_ROWS)) else $error("row overflow");
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> done_r) else $error("found without done");
endmodule
`default_nettype wire

// ===== rtl/pqsa_ctrl.sv =====
// ---------------------------------------------------------------------------
// pqsa_ctrl: sequencer for one word at a time.
// Captures a word, runs the search on serves, commits, then offers the result.
// ---------------------------------------------------------------------------
`default_nettype none
module pqsa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output pqsa_pkg::dp_cmd_t       cmd,
  input  wire pqsa_pkg::dp_stat_t stat
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_EXEC, S_OUT} state_t;
  state_t state_r;
  logic   valid_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = valid_r;
  assign cmd.load      = in_tvalid && in_tready;
  assign cmd.scan_step = (state_r == S_SCAN);
  assign cmd.execute   = (state_r == S_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_tvalid) state_r <= S_SCAN;
        S_SCAN: if (!stat.is_serve || stat.scan_done) state_r <= S_READ;
        S_READ: state_r <= S_EXEC;
        S_EXEC: begin
          valid_r <= 1'b1; state_r <= S_OUT;
        end
        S_OUT: if (out_tready) begin
          valid_r <= 1'b0; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == S_OUT) else $error("valid outside output state");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accepted while holding result");
  a_exec_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> out_tvalid) else $error("result not raised");
endmodule
`default_nettype wire
